// ===== design/qco_pkg.sv =====
// shared types and constants for the quad corner orderer
// no dependencies; used by quad_corner_orderer
package qco_pkg;

    localparam int NUM_CORNERS = 4;
    localparam int IN_FIELDS   = 10;
    localparam int OUT_FIELDS  = 8;

    typedef logic [1:0] corner_idx_t;

    // corner roles carried down the back half of the pipeline
    typedef struct packed {
        corner_idx_t bl;
        corner_idx_t br;
        corner_idx_t c;
        corner_idx_t e;
    } role_t;

endpackage

// ===== design/qco_sq_sum.sv =====
// registered sum of two squares of signed differences
// depends on nothing; instantiated by quad_corner_orderer
module qco_sq_sum #(
    parameter int DW = 13
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [DW-1:0] a,
    input  logic signed [DW-1:0] b,
    output logic [2*DW-2:0]     q
);

    logic signed [2*DW-1:0] pa;
    logic signed [2*DW-1:0] pb;
    logic [2*DW-1:0]        sum;
    logic [2*DW-2:0]        q_reg;

    assign pa  = a * a;
    assign pb  = b * b;
    // both terms are non-negative, the sum fits one bit less than the product width
    assign sum = $unsigned(pa) + $unsigned(pb);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= sum[2*DW-2:0];
        end
    end

    assign q = q_reg;

endmodule

// ===== design/quad_corner_orderer.sv =====
// quad_corner_orderer: orders four corners as top-left, top-right, bottom-right, bottom-left
// seven register stages from input transaction to m_tvalid
// throughput: one transaction per cycle while m_tready does not stall it, seven stage pipeline with per-stage stall
// reset clears the stage valid bits only; data registers are not reset
// depends on qco_pkg and qco_sq_sum
module quad_corner_orderer #(
    parameter int COORD_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, ref_x, ref_y
    input  logic [((qco_pkg::IN_FIELDS * COORD_BITS + 7) / 8) * 8 - 1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // top_left_x, top_left_y, top_right_x, top_right_y,
    // bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y
    output logic [((qco_pkg::OUT_FIELDS * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int NC    = qco_pkg::NUM_CORNERS;
    localparam int OUT_W = ((qco_pkg::OUT_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int DW    = CB + 1;
    localparam int SW    = 2 * DW - 1;
    localparam int PW    = 2 * DW;

    // stage valid bits and enables
    logic [7:1] v_reg;
    logic [7:1] en;

    assign en[7] = !v_reg[7] || m_tready;
    assign en[6] = !v_reg[6] || en[7];
    assign en[5] = !v_reg[5] || en[6];
    assign en[4] = !v_reg[4] || en[5];
    assign en[3] = !v_reg[3] || en[4];
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];

    assign s_tready = en[1];
    assign m_tvalid = v_reg[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1]) v_reg[1] <= s_tvalid;
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
            if (en[4]) v_reg[4] <= v_reg[3];
            if (en[5]) v_reg[5] <= v_reg[4];
            if (en[6]) v_reg[6] <= v_reg[5];
            if (en[7]) v_reg[7] <= v_reg[6];
        end
    end

    // stage 1: offsets from reference
    logic [NC*CB-1:0] px_next;
    logic [NC*CB-1:0] py_next;
    logic [NC*DW-1:0] dx_next;
    logic [NC*DW-1:0] dy_next;
    logic [NC*CB-1:0] px1_reg, px2_reg, px3_reg, px4_reg, px5_reg, px6_reg;
    logic [NC*CB-1:0] py1_reg, py2_reg, py3_reg, py4_reg, py5_reg, py6_reg;
    logic [NC*DW-1:0] dx1_reg, dx2_reg, dx3_reg;
    logic [NC*DW-1:0] dy1_reg, dy2_reg, dy3_reg;

    always_comb
    begin
        logic [CB-1:0] rx;
        logic [CB-1:0] ry;
        rx = s_tdata[8*CB +: CB];
        ry = s_tdata[9*CB +: CB];
        for (int i = 0; i < NC; i++)
        begin
            px_next[i*CB +: CB] = s_tdata[(2*i)*CB +: CB];
            py_next[i*CB +: CB] = s_tdata[(2*i+1)*CB +: CB];
            dx_next[i*DW +: DW] = {1'b0, s_tdata[(2*i)*CB +: CB]} - {1'b0, rx};
            dy_next[i*DW +: DW] = {1'b0, s_tdata[(2*i+1)*CB +: CB]} - {1'b0, ry};
        end
    end

    // stage 2: squared distances to reference
    logic [NC*SW-1:0] d2;

    for (genvar g = 0; g < NC; g++)
    begin : g_dist
        qco_sq_sum #(.DW(DW)) u_dist (
            .clk (clk),
            .en  (en[2]),
            .a   ($signed(dx1_reg[g*DW +: DW])),
            .b   ($signed(dy1_reg[g*DW +: DW])),
            .q   (d2[g*SW +: SW])
        );
    end

    // stage 3: nearest two corners and the remaining pair
    qco_pkg::corner_idx_t ia_next, ib_next, ic_next, ie_next;
    qco_pkg::corner_idx_t ia3_reg, ib3_reg, ic3_reg, ie3_reg;

    always_comb
    begin
        logic found_b;
        logic found_c;
        ia_next = '0;
        ib_next = '0;
        ic_next = '0;
        ie_next = '0;
        found_b = 1'b0;
        found_c = 1'b0;
        for (int i = 1; i < NC; i++)
        begin
            if (d2[i*SW +: SW] < d2[ia_next*SW +: SW])
                ia_next = 2'(i);
        end
        for (int i = 0; i < NC; i++)
        begin
            if (2'(i) != ia_next && (!found_b || d2[i*SW +: SW] < d2[ib_next*SW +: SW]))
            begin
                ib_next = 2'(i);
                found_b = 1'b1;
            end
        end
        for (int i = 0; i < NC; i++)
        begin
            if (2'(i) != ia_next && 2'(i) != ib_next)
            begin
                if (!found_c)
                begin
                    ic_next = 2'(i);
                    found_c = 1'b1;
                end
                else
                begin
                    ie_next = 2'(i);
                end
            end
        end
    end

    // stage 4: cross product sign picks bottom-left
    logic signed [DW-1:0] ax, ay, bx, by;
    logic signed [PW-1:0] p_bxay, p_byax;
    logic signed [PW:0]   z;
    qco_pkg::role_t       role_next;
    qco_pkg::role_t       role4_reg, role5_reg, role6_reg;

    assign ax     = $signed(dx3_reg[ia3_reg*DW +: DW]);
    assign ay     = $signed(dy3_reg[ia3_reg*DW +: DW]);
    assign bx     = $signed(dx3_reg[ib3_reg*DW +: DW]);
    assign by     = $signed(dy3_reg[ib3_reg*DW +: DW]);
    assign p_bxay = bx * ay;
    assign p_byax = by * ax;
    assign z      = PW'(p_bxay) - PW'(p_byax);

    always_comb
    begin
        role_next.c = ic3_reg;
        role_next.e = ie3_reg;
        if (z[PW])
        begin
            role_next.bl = ia3_reg;
            role_next.br = ib3_reg;
        end
        else
        begin
            role_next.bl = ib3_reg;
            role_next.br = ia3_reg;
        end
    end

    // stage 5: offsets of the top pair from bottom-left
    logic [DW-1:0] cx_next, cy_next, ex_next, ey_next;
    logic [DW-1:0] cx5_reg, cy5_reg, ex5_reg, ey5_reg;

    assign cx_next = {1'b0, px4_reg[role4_reg.bl*CB +: CB]}
                   - {1'b0, px4_reg[role4_reg.c*CB +: CB]};
    assign cy_next = {1'b0, py4_reg[role4_reg.bl*CB +: CB]}
                   - {1'b0, py4_reg[role4_reg.c*CB +: CB]};
    assign ex_next = {1'b0, px4_reg[role4_reg.bl*CB +: CB]}
                   - {1'b0, px4_reg[role4_reg.e*CB +: CB]};
    assign ey_next = {1'b0, py4_reg[role4_reg.bl*CB +: CB]}
                   - {1'b0, py4_reg[role4_reg.e*CB +: CB]};

    // stage 6: squared distances of the top pair to bottom-left
    logic [SW-1:0] dc6, de6;

    qco_sq_sum #(.DW(DW)) u_dist_c (
        .clk (clk),
        .en  (en[6]),
        .a   ($signed(cx5_reg)),
        .b   ($signed(cy5_reg)),
        .q   (dc6)
    );

    qco_sq_sum #(.DW(DW)) u_dist_e (
        .clk (clk),
        .en  (en[6]),
        .a   ($signed(ex5_reg)),
        .b   ($signed(ey5_reg)),
        .q   (de6)
    );

    // stage 7: top-left is the strictly nearer one, ties go to the later index
    qco_pkg::corner_idx_t tl, tr;
    logic [OUT_W-1:0]     out_next;
    logic [OUT_W-1:0]     out_reg;

    assign tl = (dc6 < de6) ? role6_reg.c : role6_reg.e;
    assign tr = (dc6 < de6) ? role6_reg.e : role6_reg.c;

    always_comb
    begin
        out_next = '0;
        out_next[0*CB +: CB] = px6_reg[tl*CB +: CB];
        out_next[1*CB +: CB] = py6_reg[tl*CB +: CB];
        out_next[2*CB +: CB] = px6_reg[tr*CB +: CB];
        out_next[3*CB +: CB] = py6_reg[tr*CB +: CB];
        out_next[4*CB +: CB] = px6_reg[role6_reg.br*CB +: CB];
        out_next[5*CB +: CB] = py6_reg[role6_reg.br*CB +: CB];
        out_next[6*CB +: CB] = px6_reg[role6_reg.bl*CB +: CB];
        out_next[7*CB +: CB] = py6_reg[role6_reg.bl*CB +: CB];
    end

    assign m_tdata = out_reg;

    // data registers
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            px1_reg <= px_next;
            py1_reg <= py_next;
            dx1_reg <= dx_next;
            dy1_reg <= dy_next;
        end
        if (en[2])
        begin
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
        end
        if (en[3])
        begin
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            ia3_reg <= ia_next;
            ib3_reg <= ib_next;
            ic3_reg <= ic_next;
            ie3_reg <= ie_next;
        end
        if (en[4])
        begin
            px4_reg   <= px3_reg;
            py4_reg   <= py3_reg;
            role4_reg <= role_next;
        end
        if (en[5])
        begin
            px5_reg   <= px4_reg;
            py5_reg   <= py4_reg;
            role5_reg <= role4_reg;
            cx5_reg   <= cx_next;
            cy5_reg   <= cy_next;
            ex5_reg   <= ex_next;
            ey5_reg   <= ey_next;
        end
        if (en[6])
        begin
            px6_reg   <= px5_reg;
            py6_reg   <= py5_reg;
            role6_reg <= role5_reg;
        end
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

endmodule
